FILE: sv/prac_pkg.sv
// ----------------------------------------------------------------------------
// prac_pkg: shared types and constants for point rotation about a center
// Coordinate formats, payload structs, angle and phase constants, and the
// arctangent and phase tables used by the rotation pipeline.
// ----------------------------------------------------------------------------
package prac_pkg;

    // Coordinates are signed Q16.8.
    localparam int COORD_WIDTH = 24;
    localparam int ANGLE_WIDTH = 17;

    // Configuration port.
    localparam int CFG_DATA_WIDTH  = 24;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANGLE    = 2'd2;

    // Angles are in 1/128 degree.
    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;
    localparam int ANGLE_RED_W  = 16;   // reduced angle, below one full turn
    localparam int REM_W        = 14;   // remainder below one quarter turn

    // The phase is r * 2^22 / 45 rounded; r is split as 45 * k + m.
    localparam int DIV45       = 45;
    localparam int RECIP45     = 23302; // ceil(2^20 / 45)
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 15;
    localparam int K_W         = 8;
    localparam int M_W         = 6;
    localparam int Z_FRAC_W    = 22;
    localparam int Z_W         = K_W + Z_FRAC_W;

    // CORDIC datapath.
    localparam int CORDIC_W   = 33;
    localparam int CS_W       = 32;
    localparam int KINV_Q30   = 652032874;
    localparam int MAX_STAGES = 32;

    typedef logic [Z_FRAC_W-1:0] t_zfrac_tab [2**M_W];

    // floor((m * 2^22 + 22) / 45) for every remainder m below 45.
    function automatic t_zfrac_tab build_zfrac_tab();
        t_zfrac_tab tab;
        longint num;
        for (int m = 0; m < 2**M_W; m++) begin
            num = (longint'(m) <<< Z_FRAC_W) + longint'(DIV45 / 2);
            if (m < DIV45) begin
                tab[m] = Z_FRAC_W'(num / DIV45);
            end else begin
                tab[m] = '0;
            end
        end
        return tab;
    endfunction

    localparam t_zfrac_tab ZFRAC_TAB = build_zfrac_tab();

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] t;
        case (i)
            0:       t = 32'h20000000;
            1:       t = 32'h12E4051E;
            2:       t = 32'h09FB385B;
            3:       t = 32'h051111D4;
            4:       t = 32'h028B0D43;
            5:       t = 32'h0145D7E1;
            6:       t = 32'h00A2F61E;
            7:       t = 32'h00517C55;
            8:       t = 32'h0028BE53;
            9:       t = 32'h00145F2F;
            10:      t = 32'h000A2F98;
            11:      t = 32'h000517CC;
            12:      t = 32'h00028BE6;
            13:      t = 32'h000145F3;
            14:      t = 32'h0000A2FA;
            15:      t = 32'h0000517D;
            16:      t = 32'h000028BE;
            17:      t = 32'h0000145F;
            18:      t = 32'h00000A30;
            19:      t = 32'h00000518;
            20:      t = 32'h0000028C;
            21:      t = 32'h00000146;
            22:      t = 32'h000000A3;
            23:      t = 32'h00000051;
            24:      t = 32'h00000029;
            25:      t = 32'h00000014;
            26:      t = 32'h0000000A;
            27:      t = 32'h00000005;
            28:      t = 32'h00000003;
            29:      t = 32'h00000001;
            30:      t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
    } t_point;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rotated_x;
        logic signed [COORD_WIDTH-1:0] rotated_y;
        logic                          saturated;
    } t_result;

    // Offset from the center after the quarter turns, carried beside the CORDIC.
    typedef struct packed {
        logic signed [COORD_WIDTH:0] tx;
        logic signed [COORD_WIDTH:0] ty;
        logic                        bypass;
    } t_side;

endpackage

FILE: sv/prac_cordic.sv
// ----------------------------------------------------------------------------
// prac_cordic: unrolled rotation-mode CORDIC for cosine and sine
// One register stage per iteration, then a rounding stage to Q28.
// ----------------------------------------------------------------------------
module prac_cordic #(
    parameter int STAGES = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [prac_pkg::Z_W-1:0]            i_z,
    output logic                                o_valid,
    output logic signed [prac_pkg::CS_W-1:0]    o_cos,
    output logic signed [prac_pkg::CS_W-1:0]    o_sin
);

    localparam int CW = prac_pkg::CORDIC_W;
    localparam logic signed [CW-1:0] X_INIT = CW'(prac_pkg::KINV_Q30);
    localparam logic signed [CW-1:0] ROUND2 = CW'(2);

    logic signed [CW-1:0] r_x [STAGES];
    logic signed [CW-1:0] r_y [STAGES];
    logic signed [CW-1:0] r_z [STAGES];
    logic                 r_v [STAGES];

    logic signed [CW-1:0] x_rnd;
    logic signed [CW-1:0] y_rnd;
    logic                 r_out_v;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [CW-1:0] z_in;
        logic                 v_in;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [CW-1:0] n_z;
        logic signed [CW-1:0] atan_g;

        if (g == 0) begin : g_first
            assign x_in = X_INIT;
            assign y_in = '0;
            assign z_in = CW'(i_z);
            assign v_in = i_valid;
        end else begin : g_next
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
            assign v_in = r_v[g-1];
        end

        assign atan_g = CW'(prac_pkg::atan_turn(g));

        // A negative residual phase turns the vector clockwise.
        always_comb begin
            if (z_in[CW-1]) begin
                n_x = x_in + (y_in >>> g);
                n_y = y_in - (x_in >>> g);
                n_z = z_in + atan_g;
            end else begin
                n_x = x_in - (y_in >>> g);
                n_y = y_in + (x_in >>> g);
                n_z = z_in - atan_g;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[g] <= n_x;
            r_y[g] <= n_y;
            r_z[g] <= n_z;
        end
    end

    assign x_rnd = (r_x[STAGES-1] + ROUND2) >>> 2;
    assign y_rnd = (r_y[STAGES-1] + ROUND2) >>> 2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_cos <= x_rnd[prac_pkg::CS_W-1:0];
        o_sin <= y_rnd[prac_pkg::CS_W-1:0];
    end

    assign o_valid = r_out_v;

endmodule

FILE: sv/point_rotation_about_center.sv
// ----------------------------------------------------------------------------
// point_rotation_about_center: rotates points about a configured center
// Throughput: one transaction per cycle whenever the block is out of reset;
// every stage is a register, so the unrolled CORDIC sets the depth and
// nothing stalls. The receiver cannot stall.
// Reset is synchronous; while i_rst_n is low busy is high, the pipeline
// empties, and the center and angle return to zero.
// ----------------------------------------------------------------------------
module point_rotation_about_center #(
    parameter int ROTATION_STAGES = 20
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  prac_pkg::t_point                        i_point,
    output logic                                    o_strobe,
    output prac_pkg::t_result                       o_result,
    input  logic                                    i_cfg_we,
    input  logic [prac_pkg::CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [prac_pkg::CFG_DATA_WIDTH-1:0]     i_cfg_data
);

    // Datapath widths. The offset from the center needs one bit more than a
    // coordinate, the products carry the Q28 cosine and sine, and the last
    // sum with the center needs one more bit before it is clipped.
    localparam int CWD   = prac_pkg::COORD_WIDTH;
    localparam int DW    = CWD + 1;
    localparam int PW    = DW + prac_pkg::CS_W;
    localparam int SW    = PW + 1;
    localparam int SHW   = SW - 28;
    localparam int FW    = SHW + 1;
    localparam int AR_W  = prac_pkg::ANGLE_WIDTH + 2;
    localparam int KP_W  = prac_pkg::REM_W + prac_pkg::RECIP_W;
    localparam int DLY   = ROTATION_STAGES + 1;

    localparam logic signed [AR_W-1:0] FULL_S  = AR_W'(prac_pkg::FULL_TURN);
    localparam logic signed [AR_W-1:0] FULL2_S = AR_W'(2 * prac_pkg::FULL_TURN);
    localparam logic [prac_pkg::ANGLE_RED_W-1:0] Q1_A =
        prac_pkg::ANGLE_RED_W'(prac_pkg::QUARTER_TURN);
    localparam logic [prac_pkg::ANGLE_RED_W-1:0] Q2_A =
        prac_pkg::ANGLE_RED_W'(2 * prac_pkg::QUARTER_TURN);
    localparam logic [prac_pkg::ANGLE_RED_W-1:0] Q3_A =
        prac_pkg::ANGLE_RED_W'(3 * prac_pkg::QUARTER_TURN);
    localparam logic signed [SW-1:0] HALF_Q28 = SW'(longint'(1) <<< 27);
    localparam logic signed [FW-1:0] OUT_MAX  = FW'((longint'(1) <<< (CWD - 1)) - 1);
    localparam logic signed [FW-1:0] OUT_MIN  = -OUT_MAX - FW'(1);

    typedef enum logic [1:0] {
        QTR_0,
        QTR_90,
        QTR_180,
        QTR_270
    } t_quarter;

    // ------------------------------------------------------------------
    // Configuration registers. Writes must come only while the pipeline is
    // empty; the block does not enforce this. Every stage then reads them directly.
    // ------------------------------------------------------------------
    logic signed [CWD-1:0]                    r_center_x;
    logic signed [CWD-1:0]                    r_center_y;
    logic signed [prac_pkg::ANGLE_WIDTH-1:0]  r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_angle    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                prac_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data[CWD-1:0];
                prac_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data[CWD-1:0];
                prac_pkg::CFG_ANGLE:    r_angle    <= i_cfg_data[prac_pkg::ANGLE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline never stalls, so a transaction is taken whenever the
    // block is out of reset.
    assign busy = ~i_rst_n;

    logic accept;
    assign accept = start & ~busy;

    // ------------------------------------------------------------------
    // Stage 1: offset from the center, and the angle reduced into one turn.
    // The register holds under one and a half turns either way, so two
    // corrections are enough.
    // ------------------------------------------------------------------
    logic                                 r_s1_v;
    logic signed [DW-1:0]                 r_s1_dx;
    logic signed [DW-1:0]                 r_s1_dy;
    logic [prac_pkg::ANGLE_RED_W-1:0]     r_s1_a;

    logic signed [DW-1:0]                 n_s1_dx;
    logic signed [DW-1:0]                 n_s1_dy;
    logic [prac_pkg::ANGLE_RED_W-1:0]     n_s1_a;
    logic signed [AR_W-1:0]               ang_ext;
    logic signed [AR_W-1:0]               ang_plus;
    logic signed [AR_W-1:0]               ang_red;

    assign n_s1_dx = DW'(i_point.point_x) - DW'(r_center_x);
    assign n_s1_dy = DW'(i_point.point_y) - DW'(r_center_y);

    always_comb begin
        ang_ext  = AR_W'(r_angle);
        ang_plus = ang_ext + FULL_S;
        if (ang_ext < 0) begin
            ang_red = (ang_plus < 0) ? (ang_ext + FULL2_S) : ang_plus;
        end else if (ang_ext >= FULL_S) begin
            ang_red = ang_ext - FULL_S;
        end else begin
            ang_red = ang_ext;
        end
        n_s1_a = ang_red[prac_pkg::ANGLE_RED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_dx <= n_s1_dx;
        r_s1_dy <= n_s1_dy;
        r_s1_a  <= n_s1_a;
    end

    // ------------------------------------------------------------------
    // Stage 2: whole quarter turns as exact swaps and negations, plus the
    // remainder below a quarter turn. A zero remainder skips the CORDIC.
    // ------------------------------------------------------------------
    logic                         r_s2_v;
    prac_pkg::t_side              r_s2_side;
    logic [prac_pkg::REM_W-1:0]   r_s2_r;

    t_quarter                     quarter;
    logic [prac_pkg::ANGLE_RED_W-1:0] quarter_base;
    logic [prac_pkg::REM_W-1:0]   n_s2_r;
    prac_pkg::t_side              n_s2_side;

    always_comb begin
        if (r_s1_a >= Q3_A) begin
            quarter      = QTR_270;
            quarter_base = Q3_A;
        end else if (r_s1_a >= Q2_A) begin
            quarter      = QTR_180;
            quarter_base = Q2_A;
        end else if (r_s1_a >= Q1_A) begin
            quarter      = QTR_90;
            quarter_base = Q1_A;
        end else begin
            quarter      = QTR_0;
            quarter_base = '0;
        end
    end

    always_comb begin
        n_s2_r = prac_pkg::REM_W'(r_s1_a - quarter_base);
        case (quarter)
            QTR_90: begin
                n_s2_side.tx = -r_s1_dy;
                n_s2_side.ty = r_s1_dx;
            end
            QTR_180: begin
                n_s2_side.tx = -r_s1_dx;
                n_s2_side.ty = -r_s1_dy;
            end
            QTR_270: begin
                n_s2_side.tx = r_s1_dy;
                n_s2_side.ty = -r_s1_dx;
            end
            default: begin
                n_s2_side.tx = r_s1_dx;
                n_s2_side.ty = r_s1_dy;
            end
        endcase
        n_s2_side.bypass = (n_s2_r == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_side <= n_s2_side;
        r_s2_r    <= n_s2_r;
    end

    // ------------------------------------------------------------------
    // Stages 3 to 5: the phase r * 2^32 / 46080, rounded, equals
    // floor((r * 2^22 + 22) / 45). With r = 45k + m this is k * 2^22 plus a
    // table entry for m. The quotient k comes from a reciprocal multiply that
    // is exact over the whole remainder range.
    // ------------------------------------------------------------------
    logic                         r_s3_v;
    prac_pkg::t_side              r_s3_side;
    logic [prac_pkg::REM_W-1:0]   r_s3_r;
    logic [prac_pkg::K_W-1:0]     r_s3_k;
    logic [KP_W-1:0]              k_prod;

    assign k_prod = KP_W'(r_s2_r) * KP_W'(prac_pkg::RECIP45);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_side <= r_s2_side;
        r_s3_r    <= r_s2_r;
        r_s3_k    <= k_prod[prac_pkg::RECIP_SHIFT +: prac_pkg::K_W];
    end

    logic                         r_s4_v;
    prac_pkg::t_side              r_s4_side;
    logic [prac_pkg::K_W-1:0]     r_s4_k;
    logic [prac_pkg::M_W-1:0]     r_s4_m;
    logic [prac_pkg::REM_W-1:0]   k_times45;
    logic [prac_pkg::REM_W-1:0]   m_full;

    assign k_times45 = prac_pkg::REM_W'(prac_pkg::REM_W'(r_s3_k) * prac_pkg::REM_W'(prac_pkg::DIV45));
    assign m_full    = r_s3_r - k_times45;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_side <= r_s3_side;
        r_s4_k    <= r_s3_k;
        r_s4_m    <= m_full[prac_pkg::M_W-1:0];
    end

    logic                         r_s5_v;
    prac_pkg::t_side              r_s5_side;
    logic [prac_pkg::Z_W-1:0]     r_s5_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else begin
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_side <= r_s4_side;
        r_s5_z    <= {r_s4_k, prac_pkg::ZFRAC_TAB[r_s4_m]};
    end

    // ------------------------------------------------------------------
    // CORDIC: ROTATION_STAGES iterations and one rounding stage. The turned
    // offset waits in a delay line of the same depth.
    // ------------------------------------------------------------------
    logic                              cordic_v;
    logic signed [prac_pkg::CS_W-1:0]  cordic_cos;
    logic signed [prac_pkg::CS_W-1:0]  cordic_sin;
    prac_pkg::t_side                   r_dly [DLY];

    prac_cordic #(
        .STAGES (ROTATION_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s5_v),
        .i_z     (r_s5_z),
        .o_valid (cordic_v),
        .o_cos   (cordic_cos),
        .o_sin   (cordic_sin)
    );

    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_s5_side;
        for (int i = 1; i < DLY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Product stage: the four products of the offset with cosine and sine.
    // ------------------------------------------------------------------
    logic                   r_p1_v;
    prac_pkg::t_side        r_p1_side;
    logic signed [PW-1:0]   r_p_xc;
    logic signed [PW-1:0]   r_p_ys;
    logic signed [PW-1:0]   r_p_xs;
    logic signed [PW-1:0]   r_p_yc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= cordic_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_side <= r_dly[DLY-1];
        r_p_xc    <= PW'(r_dly[DLY-1].tx) * PW'(cordic_cos);
        r_p_ys    <= PW'(r_dly[DLY-1].ty) * PW'(cordic_sin);
        r_p_xs    <= PW'(r_dly[DLY-1].tx) * PW'(cordic_sin);
        r_p_yc    <= PW'(r_dly[DLY-1].ty) * PW'(cordic_cos);
    end

    // ------------------------------------------------------------------
    // Sum stage: combine, round half up and drop the Q28 fraction. A whole
    // quarter-turn angle takes the exactly turned offset instead.
    // ------------------------------------------------------------------
    logic                   r_p2_v;
    logic signed [SHW-1:0]  r_p2_x;
    logic signed [SHW-1:0]  r_p2_y;
    logic signed [SW-1:0]   sum_x;
    logic signed [SW-1:0]   sum_y;
    logic signed [SHW-1:0]  n_p2_x;
    logic signed [SHW-1:0]  n_p2_y;

    always_comb begin
        sum_x = SW'(r_p_xc) - SW'(r_p_ys) + HALF_Q28;
        sum_y = SW'(r_p_xs) + SW'(r_p_yc) + HALF_Q28;
        if (r_p1_side.bypass) begin
            n_p2_x = SHW'(r_p1_side.tx);
            n_p2_y = SHW'(r_p1_side.ty);
        end else begin
            n_p2_x = sum_x[SW-1:28];
            n_p2_y = sum_y[SW-1:28];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else begin
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_x <= n_p2_x;
        r_p2_y <= n_p2_y;
    end

    // ------------------------------------------------------------------
    // Output stage: add the center back and clip each coordinate to range.
    // ------------------------------------------------------------------
    logic signed [FW-1:0]   full_x;
    logic signed [FW-1:0]   full_y;
    logic signed [FW-1:0]   clip_x;
    logic signed [FW-1:0]   clip_y;
    logic                   sat_x;
    logic                   sat_y;
    logic                   r_out_v;
    prac_pkg::t_result      n_result;

    always_comb begin
        full_x = FW'(r_p2_x) + FW'(r_center_x);
        full_y = FW'(r_p2_y) + FW'(r_center_y);

        sat_x  = 1'b1;
        if (full_x > OUT_MAX) begin
            clip_x = OUT_MAX;
        end else if (full_x < OUT_MIN) begin
            clip_x = OUT_MIN;
        end else begin
            clip_x = full_x;
            sat_x  = 1'b0;
        end

        sat_y  = 1'b1;
        if (full_y > OUT_MAX) begin
            clip_y = OUT_MAX;
        end else if (full_y < OUT_MIN) begin
            clip_y = OUT_MIN;
        end else begin
            clip_y = full_y;
            sat_y  = 1'b0;
        end

        n_result.rotated_x = clip_x[CWD-1:0];
        n_result.rotated_y = clip_y[CWD-1:0];
        n_result.saturated = sat_x | sat_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_result;
    end

    assign o_strobe = r_out_v;

endmodule

FILE: sv/prac_checker.sv
// ----------------------------------------------------------------------------
// prac_checker: port-level checks for point rotation about a center
// Watches reset, the fixed latency from transaction to result and the
// meaning of the saturation flag.
// ----------------------------------------------------------------------------
module prac_checker #(
    parameter int LATENCY = 29
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    input  logic                                    busy,
    input  logic                                    o_strobe,
    input  prac_pkg::t_result                       o_result
);

    localparam logic signed [prac_pkg::COORD_WIDTH-1:0] C_MAX =
        {1'b0, {(prac_pkg::COORD_WIDTH-1){1'b1}}};
    localparam logic signed [prac_pkg::COORD_WIDTH-1:0] C_MIN =
        {1'b1, {(prac_pkg::COORD_WIDTH-1){1'b0}}};

    // Reset empties the pipeline.
    a_reset_flush: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    // Every transaction gives exactly one result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("transaction without result at the expected cycle");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transaction");

    // A clipped result sits at an end of the coordinate range.
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.saturated) |->
            (o_result.rotated_x == C_MAX || o_result.rotated_x == C_MIN ||
             o_result.rotated_y == C_MAX || o_result.rotated_y == C_MIN))
        else $error("saturation flag with an unclipped result");

endmodule

bind point_rotation_about_center prac_checker #(
    .LATENCY (ROTATION_STAGES + 9)
) u_prac_checker (.*);

FILE: bench/point_rotation_about_center_tb.sv
// ----------------------------------------------------------------------------
// point_rotation_about_center_tb: self-checking bench for point rotation
// A short table of hand-picked points and settings runs first. Random phases
// follow, each with a new angle and often a new center. Every accepted transaction
// is predicted by a bit-exact model kept in the bench, or typed in by hand,
// and each strobed result is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module point_rotation_about_center_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The bench predicts with the same stage count it gives the block.
    localparam int ROT_STAGES = 20;

    // The block's pipeline depth, plus some margin. The tail of the run waits
    // this long after the last result so that a stray extra strobe is caught.
    localparam int TAIL_CYCLES = ROT_STAGES + 20;

    // The limit covers the slowest correct run: every item can face the
    // longest gap and a full drain, and every phase change drains the
    // pipeline first.
    localparam int CYCLE_LIMIT = 200000;

    localparam int RANDOM_ITEMS = 600;

    // Register index 3 is not decoded. Writes to it must leave the state alone.
    localparam logic [prac_pkg::CFG_INDEX_WIDTH-1:0] CFG_SPARE = 2'd3;

    localparam int     C_MAX    = 2**(prac_pkg::COORD_WIDTH-1) - 1;
    localparam int     C_MIN    = -(2**(prac_pkg::COORD_WIDTH-1));
    localparam longint COORD_HI = C_MAX;
    localparam longint COORD_LO = C_MIN;

    // Angle steps of the rotation stages, atan(2^-i), in units of 2^-32 turn.
    localparam longint ARCTAN_TURN [32] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
        'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
        'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D,
        'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
        'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
        'h00000029, 'h00000014, 'h0000000A, 'h00000005,
        'h00000003, 'h00000001, 'h00000001, 'h00000000
    };

    // One row of the directed table. Each row gives the center and angle that
    // must be in force, the point to send, and, where the answer is plain,
    // the result typed in by hand. When poke_spare is set, the bench writes
    // the undecoded index before the row, and the row checks that nothing
    // changed.
    typedef struct packed {
        int cx;
        int cy;
        int ang;
        int px;
        int py;
        bit poke_spare;
        bit known;
        int ex;
        int ey;
        bit esat;
    } t_point_case;

    localparam int N_DIRECTED = 25;
    localparam int Q = prac_pkg::QUARTER_TURN;
    localparam int F = prac_pkg::FULL_TURN;

    localparam t_point_case DIRECTED_CASES [N_DIRECTED] = '{
        // With the values left by reset, the point comes back unchanged.
        '{0, 0, 0, 1000, -2000, 1'b0, 1'b1, 1000, -2000, 1'b0},
        '{0, 0, 0, C_MAX, C_MIN, 1'b0, 1'b1, C_MAX, C_MIN, 1'b0},
        '{0, 0, 0, C_MIN, C_MAX, 1'b0, 1'b1, C_MIN, C_MAX, 1'b0},
        '{0, 0, 0, -1, 1, 1'b0, 1'b1, -1, 1, 1'b0},
        // Whole quarter turns are exact swaps and negations.
        '{0, 0, Q, C_MAX, 0, 1'b0, 1'b1, 0, C_MAX, 1'b0},
        '{0, 0, Q, 0, C_MIN, 1'b0, 1'b1, C_MAX, 0, 1'b1},
        '{0, 0, Q, C_MIN, 0, 1'b0, 1'b1, 0, C_MIN, 1'b0},
        '{0, 0, 2*Q, C_MIN, C_MIN, 1'b0, 1'b1, C_MAX, C_MAX, 1'b1},
        '{0, 0, 2*Q, 300, -700, 1'b0, 1'b1, -300, 700, 1'b0},
        '{0, 0, 3*Q, 100, 200, 1'b0, 1'b1, 200, -100, 1'b0},
        '{0, 0, -Q, 256, 0, 1'b0, 1'b1, 0, -256, 1'b0},
        // A full turn in either direction reduces to no turn at all.
        '{0, 0, F, 5, 7, 1'b0, 1'b1, 5, 7, 1'b0},
        '{0, 0, -F, -5, 9, 1'b0, 1'b1, -5, 9, 1'b0},
        // A write to the undecoded index must not disturb the quarter turn.
        '{0, 0, Q, 1, 2, 1'b1, 1'b1, -2, 1, 1'b0},
        // Extreme centers: the offset needs one more bit than a coordinate.
        '{C_MAX, C_MIN, 2*Q, C_MIN, C_MAX, 1'b0, 1'b1, C_MAX, C_MIN, 1'b1},
        '{C_MAX, C_MIN, 0, 0, 0, 1'b0, 1'b1, 0, 0, 1'b0},
        '{256, -512, Q, 356, -462, 1'b0, 1'b1, 206, -412, 1'b0},
        // The remaining rows go through the rotation stages.
        '{0, 0, 1, C_MAX, C_MAX, 1'b0, 1'b0, 0, 0, 1'b0},
        '{0, 0, Q-1, 1000, 0, 1'b0, 1'b0, 0, 0, 1'b0},
        '{0, 0, 65535, 12345, -6789, 1'b0, 1'b0, 0, 0, 1'b0},
        '{0, 0, -65536, -12345, 6789, 1'b0, 1'b0, 0, 0, 1'b0},
        '{256, 256, Q/2, 512, 256, 1'b0, 1'b0, 0, 0, 1'b0},
        '{C_MIN, C_MAX, Q/3, C_MAX, C_MIN, 1'b0, 1'b0, 0, 0, 1'b0},
        '{1000, -1000, -Q/2, 1000, -1000, 1'b0, 1'b0, 0, 0, 1'b0},
        '{0, 0, 2*Q+1, -2, 3, 1'b0, 1'b0, 0, 0, 1'b0}
    };

    // Everything that the bench drives is known from time zero.
    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 start       = 1'b0;
    logic                                 busy;
    prac_pkg::t_point                     i_point     = '0;
    logic                                 o_strobe;
    prac_pkg::t_result                    o_result;
    logic                                 i_cfg_we    = 1'b0;
    logic [prac_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [prac_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data  = '0;

    // The bench's copy of the configuration, kept in step with every write.
    logic signed [prac_pkg::COORD_WIDTH-1:0] pivot_x    = '0;
    logic signed [prac_pkg::COORD_WIDTH-1:0] pivot_y    = '0;
    logic signed [prac_pkg::ANGLE_WIDTH-1:0] turn_angle = '0;

    // Predicted results, oldest first, one per accepted transaction.
    prac_pkg::t_result pending_rotations [$];
    prac_pkg::t_result want;
    int                mismatch_count = 0;
    int                cycle_count    = 0;

    point_rotation_about_center #(
        .ROTATION_STAGES(ROT_STAGES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_point     (i_point),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bit-exact prediction of one rotation. The offset from the center is
    // first turned by whole quarters. Any leftover angle becomes a phase in
    // 2^-32 turn that drives a CORDIC. Its cosine and sine, in Q28, scale the
    // offset with half-up rounding, and the sum with the center saturates.
    function automatic prac_pkg::t_result rotate_about_center(
        input prac_pkg::t_point                        p,
        input logic signed [prac_pkg::COORD_WIDTH-1:0] cx,
        input logic signed [prac_pkg::COORD_WIDTH-1:0] cy,
        input logic signed [prac_pkg::ANGLE_WIDTH-1:0] ang
    );
        longint            ox, oy, a, quarter, rem, tx, ty, rx, ry;
        longint            z, x, y, xs, ys, c, s;
        bit                clipped;
        prac_pkg::t_result res;
        ox = longint'(p.point_x) - longint'(cx);
        oy = longint'(p.point_y) - longint'(cy);
        a  = longint'(ang) % prac_pkg::FULL_TURN;
        if (a < 0) begin
            a += prac_pkg::FULL_TURN;
        end
        quarter = a / prac_pkg::QUARTER_TURN;
        rem     = a - quarter * prac_pkg::QUARTER_TURN;
        case (quarter)
            1: begin
                tx = -oy;
                ty = ox;
            end
            2: begin
                tx = -ox;
                ty = -oy;
            end
            3: begin
                tx = oy;
                ty = -ox;
            end
            default: begin
                tx = ox;
                ty = oy;
            end
        endcase
        if (rem == 0) begin
            rx = longint'(cx) + tx;
            ry = longint'(cy) + ty;
        end else begin
            z = ((rem <<< 32) + prac_pkg::FULL_TURN / 2) / prac_pkg::FULL_TURN;
            x = prac_pkg::KINV_Q30;
            y = 0;
            for (int i = 0; i < ROT_STAGES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys;
                    y += xs;
                    z -= ARCTAN_TURN[i];
                end else begin
                    x += ys;
                    y -= xs;
                    z += ARCTAN_TURN[i];
                end
            end
            c  = (x + 2) >>> 2;
            s  = (y + 2) >>> 2;
            rx = longint'(cx) + ((tx * c - ty * s + (longint'(1) <<< 27)) >>> 28);
            ry = longint'(cy) + ((tx * s + ty * c + (longint'(1) <<< 27)) >>> 28);
        end
        clipped = 1'b0;
        if (rx > COORD_HI) begin
            rx = COORD_HI;
            clipped = 1'b1;
        end else if (rx < COORD_LO) begin
            rx = COORD_LO;
            clipped = 1'b1;
        end
        if (ry > COORD_HI) begin
            ry = COORD_HI;
            clipped = 1'b1;
        end else if (ry < COORD_LO) begin
            ry = COORD_LO;
            clipped = 1'b1;
        end
        res.rotated_x = rx[prac_pkg::COORD_WIDTH-1:0];
        res.rotated_y = ry[prac_pkg::COORD_WIDTH-1:0];
        res.saturated = clipped;
        return res;
    endfunction

    // One of the coordinates that most often break things: both ends, zero,
    // and the values next to zero.
    function automatic longint pick_extreme();
        case ($urandom_range(0, 4))
            0:       return COORD_LO;
            1:       return COORD_HI;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    // Most coordinates land near the given base, at a spread of random scale.
    // Rotations then stay mostly in range and exercise the rounding. The rest
    // are drawn from the whole range, or from the extremes, to force
    // saturation.
    function automatic logic signed [prac_pkg::COORD_WIDTH-1:0] pick_coord(
        input longint base
    );
        longint v;
        int     sel;
        int     spread;
        sel = $urandom_range(0, 19);
        if (sel < 12) begin
            spread = $urandom_range(0, prac_pkg::COORD_WIDTH - 1);
            v = base + (longint'($urandom) & ((longint'(1) <<< (spread + 1)) - 1))
                - (longint'(1) <<< spread);
        end else if (sel < 17) begin
            v = longint'($signed(prac_pkg::COORD_WIDTH'($urandom)));
        end else begin
            v = pick_extreme();
        end
        if (v > COORD_HI) begin
            v = COORD_HI;
        end else if (v < COORD_LO) begin
            v = COORD_LO;
        end
        return v[prac_pkg::COORD_WIDTH-1:0];
    endfunction

    // Holds off the sender until every pending transaction has produced its
    // result. Once that happens the pipeline is empty, and the registers may
    // be written.
    task automatic settle();
        start <= 1'b0;
        while (pending_rotations.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One register write takes effect at the next rising edge. The bench's
    // copy is updated to match. Only the low bits that the register holds are
    // kept.
    task automatic write_reg(input logic [prac_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [prac_pkg::CFG_DATA_WIDTH-1:0]  data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            prac_pkg::CFG_CENTER_X: pivot_x    = data[prac_pkg::COORD_WIDTH-1:0];
            prac_pkg::CFG_CENTER_Y: pivot_y    = data[prac_pkg::COORD_WIDTH-1:0];
            prac_pkg::CFG_ANGLE:    turn_angle = data[prac_pkg::ANGLE_WIDTH-1:0];
            default:                ;
        endcase
    endtask

    // Presents one point and holds it until the block takes it. The block
    // takes a point at an edge where start was high and busy was low. At that
    // edge the result is predicted, or the typed-in one is queued. start is
    // left high, so that back-to-back transactions need no second assignment
    // in the same step.
    task automatic send_point(input prac_pkg::t_point  p,
                              input bit                known,
                              input prac_pkg::t_result typed);
        start   <= 1'b1;
        i_point <= p;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        if (known) begin
            pending_rotations.push_back(typed);
        end else begin
            pending_rotations.push_back(rotate_about_center(p, pivot_x, pivot_y, turn_angle));
        end
    endtask

    // Result checker. Outputs are sampled at the rising edge, before any
    // update made at that edge, so a strobed result is read in the cycle
    // where it is valid. A strobe with nothing pending is a failure, as is a
    // wrong field.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (pending_rotations.size() == 0) begin
                    $error("unexpected result: rotated_x %0d rotated_y %0d saturated %0d",
                           o_result.rotated_x, o_result.rotated_y, o_result.saturated);
                    mismatch_count++;
                end else begin
                    want = pending_rotations.pop_front();
                    if (o_result.rotated_x !== want.rotated_x) begin
                        $error("rotated_x: expected %0d, got %0d",
                               want.rotated_x, o_result.rotated_x);
                        mismatch_count++;
                    end
                    if (o_result.rotated_y !== want.rotated_y) begin
                        $error("rotated_y: expected %0d, got %0d",
                               want.rotated_y, o_result.rotated_y);
                        mismatch_count++;
                    end
                    if (o_result.saturated !== want.saturated) begin
                        $error("saturated: expected %0d, got %0d",
                               want.saturated, o_result.saturated);
                        mismatch_count++;
                    end
                end
            end else if (o_strobe !== 1'b0) begin
                $error("o_strobe is unknown after reset");
                mismatch_count++;
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("point_rotation_about_center verification failed");
            $finish;
        end
    end

    // Stimulus. The directed table comes first. Random phases follow, each
    // with its own angle and sender rhythm, and often a new center.
    initial begin
        t_point_case       row;
        prac_pkg::t_point  pt;
        prac_pkg::t_result typed;
        int                sent;
        int                phase_len;
        int                burst_left;
        bit                steady;
        longint            base_x;
        longint            base_y;
        logic signed [prac_pkg::ANGLE_WIDTH-1:0] ang;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A row that needs a different setting, or pokes the spare
        // index, first drains the pipeline, then writes only the registers that
        // change. The first rows need no write, so they check the values that reset leaves.
        for (int n = 0; n < N_DIRECTED; n++) begin
            row = DIRECTED_CASES[n];
            if (row.poke_spare || pivot_x != prac_pkg::COORD_WIDTH'(row.cx)
                    || pivot_y != prac_pkg::COORD_WIDTH'(row.cy)
                    || turn_angle != prac_pkg::ANGLE_WIDTH'(row.ang)) begin
                settle();
                if (row.poke_spare) begin
                    write_reg(CFG_SPARE, prac_pkg::CFG_DATA_WIDTH'($urandom));
                end
                if (pivot_x != prac_pkg::COORD_WIDTH'(row.cx)) begin
                    write_reg(prac_pkg::CFG_CENTER_X, prac_pkg::CFG_DATA_WIDTH'(row.cx));
                end
                if (pivot_y != prac_pkg::COORD_WIDTH'(row.cy)) begin
                    write_reg(prac_pkg::CFG_CENTER_Y, prac_pkg::CFG_DATA_WIDTH'(row.cy));
                end
                if (turn_angle != prac_pkg::ANGLE_WIDTH'(row.ang)) begin
                    write_reg(prac_pkg::CFG_ANGLE, prac_pkg::CFG_DATA_WIDTH'(row.ang));
                end
                i_cfg_we <= 1'b0;
            end
            pt.point_x      = prac_pkg::COORD_WIDTH'(row.px);
            pt.point_y      = prac_pkg::COORD_WIDTH'(row.py);
            typed.rotated_x = prac_pkg::COORD_WIDTH'(row.ex);
            typed.rotated_y = prac_pkg::COORD_WIDTH'(row.ey);
            typed.saturated = row.esat;
            send_point(pt, row.known, typed);
        end

        // Random part. Every phase starts from an empty pipeline, so the
        // sender pauses until all results are in at least once per phase.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();

            case ($urandom_range(0, 4))
                0: write_reg(prac_pkg::CFG_CENTER_X, '0);
                1: write_reg(prac_pkg::CFG_CENTER_X,
                             prac_pkg::CFG_DATA_WIDTH'($urandom_range(0, 131071) - 65536));
                2: write_reg(prac_pkg::CFG_CENTER_X, prac_pkg::CFG_DATA_WIDTH'($urandom));
                3: write_reg(prac_pkg::CFG_CENTER_X,
                             prac_pkg::CFG_DATA_WIDTH'(pick_extreme()));
                default: ;
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(prac_pkg::CFG_CENTER_Y, '0);
                1: write_reg(prac_pkg::CFG_CENTER_Y,
                             prac_pkg::CFG_DATA_WIDTH'($urandom_range(0, 131071) - 65536));
                2: write_reg(prac_pkg::CFG_CENTER_Y, prac_pkg::CFG_DATA_WIDTH'($urandom));
                3: write_reg(prac_pkg::CFG_CENTER_Y,
                             prac_pkg::CFG_DATA_WIDTH'(pick_extreme()));
                default: ;
            endcase

            // The angle is rewritten every phase. Quarter multiples up to
            // five quarter turns either way test the exact path and the
            // reduction. Angles just off a quarter hit the smallest CORDIC
            // phases. The top data bits carry junk that the register must drop.
            case ($urandom_range(0, 4))
                0: ang = prac_pkg::ANGLE_WIDTH'(($urandom_range(0, 10) - 5)
                                                * prac_pkg::QUARTER_TURN);
                1: ang = prac_pkg::ANGLE_WIDTH'($urandom);
                2: ang = prac_pkg::ANGLE_WIDTH'($urandom_range(0, 2 * prac_pkg::FULL_TURN)
                                                - prac_pkg::FULL_TURN);
                3: ang = prac_pkg::ANGLE_WIDTH'(($urandom_range(0, 7) - 4)
                                                * prac_pkg::QUARTER_TURN
                                                + $urandom_range(0, 128) - 64);
                default: begin
                    case ($urandom_range(0, 3))
                        0:       ang = prac_pkg::ANGLE_WIDTH'(-65536);
                        1:       ang = prac_pkg::ANGLE_WIDTH'(65535);
                        2:       ang = prac_pkg::ANGLE_WIDTH'(-prac_pkg::FULL_TURN);
                        default: ang = prac_pkg::ANGLE_WIDTH'(prac_pkg::FULL_TURN);
                    endcase
                end
            endcase
            write_reg(prac_pkg::CFG_ANGLE,
                      {(prac_pkg::CFG_DATA_WIDTH - prac_pkg::ANGLE_WIDTH)'($urandom), ang});
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_SPARE, prac_pkg::CFG_DATA_WIDTH'($urandom));
            end
            i_cfg_we <= 1'b0;

            // The sender runs in bursts with random gaps between them. Some
            // phases leave out those gaps, to hold the pipeline full.
            base_x     = longint'(pivot_x);
            base_y     = longint'(pivot_y);
            phase_len  = $urandom_range(20, 70);
            steady     = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 24);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                if (burst_left == 0) begin
                    if (!steady) begin
                        start <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                if ($urandom_range(0, 59) == 0) begin
                    settle();
                end
                pt.point_x = pick_coord(base_x);
                pt.point_y = pick_coord(base_y);
                send_point(pt, 1'b0, '0);
                burst_left--;
                sent++;
            end
        end

        // Wait for the pipeline to drain, then watch a little longer so that
        // a stray extra result is caught.
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("point_rotation_about_center verification clean");
        end else begin
            $display("point_rotation_about_center verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/prac_pkg.sv
sv/prac_cordic.sv
sv/point_rotation_about_center.sv
sv/prac_checker.sv
bench/point_rotation_about_center_tb.sv
